// ===== rtl/tsf_pkg.sv =====
`default_nettype none

package tsf_pkg;

  // Default sizes for the top-level parameters
  localparam int unsigned TEMP_WIDTH_DEF = 16;
  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned WINDOW_MAX_DEF = 64;

  // Configuration port and register widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned CFG_TIME_W = 32;
  localparam int unsigned WLEN_W     = 7;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LIMIT   = 3'd0,
    CFG_HIGH_LIMIT  = 3'd1,
    CFG_CLOSE_PAIR  = 3'd2,
    CFG_FAR_SENSOR  = 3'd3,
    CFG_IGNORE_TIME = 3'd4,
    CFG_START_TIME  = 3'd5,
    CFG_WINDOW_LEN  = 3'd6
  } cfg_idx_e;

  // Register values after reset
  localparam logic signed [LIMIT_W-1:0] LOW_LIMIT_RST   = 16'sd256;
  localparam logic signed [LIMIT_W-1:0] HIGH_LIMIT_RST  = 16'sd4992;
  localparam logic [LIMIT_W-1:0]        CLOSE_PAIR_RST  = 16'd128;
  localparam logic [LIMIT_W-1:0]        FAR_SENSOR_RST  = 16'd320;
  localparam logic [CFG_TIME_W-1:0]     IGNORE_TIME_RST = 32'd180000;
  localparam logic [CFG_TIME_W-1:0]     START_TIME_RST  = 32'd0;
  localparam logic [WLEN_W-1:0]         WINDOW_LEN_RST  = 7'd6;

  // Sensor numbering: 0 first, 1 middle, 2 third, 3 no sensor
  localparam int unsigned NUM_SENSORS = 3;
  localparam logic [1:0] SENSOR_A    = 2'd0;
  localparam logic [1:0] SENSOR_B    = 2'd1;
  localparam logic [1:0] SENSOR_C    = 2'd2;
  localparam logic [1:0] SENSOR_NONE = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic eval;
    logic mul;
    logic mean;
    logic win;
    logic div_start;
    logic load_out;
  } tsf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic any_valid;
    logic measured;
    logic div_done;
  } tsf_status_t;

endpackage

`default_nettype wire

// ===== rtl/triple_temp_sensor_fusion_top.sv =====
`default_nettype none

// Channel   Direction  Handshake                    Content
// s_axis    in         s_axis_tvalid/s_axis_tready  one reading round
// m_axis    out        m_axis_tvalid/m_axis_tready  fused result, tlast ends a window
// cfg       in         cfg_valid_i/cfg_ready_o      register index and write data
//
// A measured round passes capture, evaluate, multiply, mean, window, the serial
// window-mean divider (one quotient bit per cycle) and the output load; a round in
// the startup hold skips the divider, and a round with no valid sensor gives no result.
// A new round is taken once the previous one is handed to the output register;
// a stalled result holds there while the next round is taken and worked on.
// Reset is asynchronous, active low; it restores register defaults and clears
// sensor ignore flags and window state. Configuration is always ready.
module triple_temp_sensor_fusion_top import tsf_pkg::*; #(
  parameter int unsigned TEMP_WIDTH = TEMP_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // time_ms, temp_a, temp_b, temp_c, zero pad
  input  wire logic [((TIME_WIDTH+3*TEMP_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // present_a, present_b, present_c
  input  wire logic [NUM_SENSORS-1:0] s_axis_tuser,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // mean_temp, valid_count, low_alarm, high_alarm, fault_flag, fault_index,
  // new_fault_index, window_mean, zero pad
  output logic [((2*TEMP_WIDTH+9+7)/8)*8-1:0] m_axis_tdata,
  // phase
  output logic                       m_axis_tuser,
  // window_ready
  output logic                       m_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  tsf_cmd_t    cmd;
  tsf_status_t status;

  assign cfg_ready_o = 1'b1;

  tsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  tsf_dp #(
    .TEMP_WIDTH (TEMP_WIDTH),
    .TIME_WIDTH (TIME_WIDTH),
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_data_i    (s_axis_tdata),
    .in_present_i (s_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_data_o   (m_axis_tdata),
    .out_phase_o  (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

`ifndef SYNTH
  // A new result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten");

  // Results in the startup hold carry no alarm and no window report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |->
      (!m_axis_tdata[TEMP_WIDTH+2] && !m_axis_tdata[TEMP_WIDTH+3] && !m_axis_tlast))
    else $error("alarm or window report during startup hold");

  // A result always uses at least one sensor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[TEMP_WIDTH+1:TEMP_WIDTH] != 2'd0))
    else $error("result with no sensor counted");

  // A sensor found faulty this round shows up as ignored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[TEMP_WIDTH+8:TEMP_WIDTH+7] != SENSOR_NONE)) |->
      m_axis_tdata[TEMP_WIDTH+4])
    else $error("new fault without fault flag");
`endif

endmodule

`default_nettype wire

// ===== rtl/tsf_div.sv =====
`default_nettype none

// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero.
module tsf_div import tsf_pkg::*; #(
  parameter int unsigned NUM_W = 22,
  parameter int unsigned DEN_W = 7,
  parameter int unsigned Q_W   = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0]        den_i,
  output logic                         busy_o,
  output logic signed [Q_W-1:0]        quot_o
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic              neg_q;

  logic [NUM_W-1:0]  num_mag;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    trial;
  logic              take;
  logic [NUM_W-1:0]  quo_signed;

  // Magnitude of the dividend at start
  assign num_mag = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);

  // One restoring step
  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign take    = (shifted >= {1'b0, den_q});

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(NUM_W);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_mag;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[NUM_W-1];
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], take};
      rem_q <= take ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  // Restore the sign
  assign quo_signed = neg_q ? (~quo_q + NUM_W'(1)) : quo_q;
  assign quot_o     = quo_signed[Q_W-1:0];
  assign busy_o     = busy_q;

endmodule

`default_nettype wire

// ===== rtl/tsf_ctrl.sv =====
`default_nettype none

// Round sequencer: capture, evaluate, multiply, mean, window, divide, hand off.
module tsf_ctrl import tsf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output tsf_cmd_t   cmd_o,
  input  wire tsf_status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_MEAN,
    ST_WIN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Commands decoded from the state
  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.eval      = (state_q == ST_EVAL);
    cmd_o.mul       = (state_q == ST_MUL);
    cmd_o.mean      = (state_q == ST_MEAN);
    cmd_o.win       = (state_q == ST_WIN);
    cmd_o.div_start = (state_q == ST_DIV_GO);
    cmd_o.load_out  = (state_q == ST_OUT) && out_free;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_EVAL;
      ST_EVAL:     state_d = ST_MUL;
      ST_MUL:      state_d = status_i.any_valid ? ST_MEAN : ST_IDLE;
      ST_MEAN:     state_d = ST_WIN;
      ST_WIN:      state_d = status_i.measured ? ST_DIV_GO : ST_OUT;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (status_i.div_done) state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Output valid flag: set on load, cleared when the transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/tsf_dp.sv =====
`default_nettype none

// Datapath: configuration, sensor timers, vote, mean, window and result.
module tsf_dp import tsf_pkg::*; #(
  parameter int unsigned TEMP_WIDTH = TEMP_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire tsf_cmd_t                cmd_i,
  output tsf_status_t                  status_o,
  input  wire logic [((TIME_WIDTH+3*TEMP_WIDTH+7)/8)*8-1:0] in_data_i,
  input  wire logic [NUM_SENSORS-1:0]  in_present_i,
  input  wire logic                    cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  output logic [((2*TEMP_WIDTH+9+7)/8)*8-1:0] out_data_o,
  output logic                         out_phase_o,
  output logic                         out_last_o
);

  localparam int unsigned TW     = TEMP_WIDTH;
  localparam int unsigned MW     = TIME_WIDTH;
  localparam int unsigned OUT_DW = ((2*TEMP_WIDTH+9+7)/8)*8;
  localparam int unsigned PACK_W = 2*TEMP_WIDTH+9;
  localparam int unsigned TLW    = (MW > CFG_TIME_W) ? MW : CFG_TIME_W;
  localparam int unsigned DCW    = TW + 17;
  localparam int unsigned CNTW   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SUMW   = TW + $clog2(WINDOW_MAX);
  localparam int unsigned LENW   = (CNTW > WLEN_W) ? CNTW : WLEN_W;
  // Reciprocal of three for the three-sensor mean
  localparam int unsigned RSH    = TW + 3;
  localparam int unsigned RW     = RSH - 1;
  localparam logic [RW-1:0] RECIP3 = RW'((64'd1 << RSH) / 64'd3);
  localparam int unsigned PW     = RSH + TW + 1;

  // Configuration registers
  logic signed [LIMIT_W-1:0] low_q, high_q;
  logic [LIMIT_W-1:0]        close_q, far_q;
  logic [CFG_TIME_W-1:0]     ign_time_q, start_q;
  logic [WLEN_W-1:0]         wlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q      <= LOW_LIMIT_RST;
      high_q     <= HIGH_LIMIT_RST;
      close_q    <= CLOSE_PAIR_RST;
      far_q      <= FAR_SENSOR_RST;
      ign_time_q <= IGNORE_TIME_RST;
      start_q    <= START_TIME_RST;
      wlen_q     <= WINDOW_LEN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LOW_LIMIT:   low_q      <= cfg_data_i[LIMIT_W-1:0];
        CFG_HIGH_LIMIT:  high_q     <= cfg_data_i[LIMIT_W-1:0];
        CFG_CLOSE_PAIR:  close_q    <= cfg_data_i[LIMIT_W-1:0];
        CFG_FAR_SENSOR:  far_q      <= cfg_data_i[LIMIT_W-1:0];
        CFG_IGNORE_TIME: ign_time_q <= cfg_data_i[CFG_TIME_W-1:0];
        CFG_START_TIME:  start_q    <= cfg_data_i[CFG_TIME_W-1:0];
        CFG_WINDOW_LEN:  wlen_q     <= cfg_data_i[WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured reading round
  logic [MW-1:0]        now_q;
  logic signed [TW-1:0] temp_q [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] pres_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q     <= in_data_i[MW-1:0];
      temp_q[0] <= in_data_i[MW +: TW];
      temp_q[1] <= in_data_i[MW+TW +: TW];
      temp_q[2] <= in_data_i[MW+2*TW +: TW];
      pres_q    <= in_present_i;
    end
  end

  // Per-sensor ignore state
  logic [NUM_SENSORS-1:0] ign_flag_q;
  logic [MW-1:0]          deadline_q [NUM_SENSORS];

  // Timer expiry and sensor validity
  logic [NUM_SENSORS-1:0] ign_mid, valid_pre, valid_fin, newf_mask, ign_nxt;
  logic [MW-1:0]          since_dl [NUM_SENSORS];

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      since_dl[i]  = now_q - deadline_q[i];
      ign_mid[i]   = ign_flag_q[i] && since_dl[i][MW-1];
      valid_pre[i] = pres_q[i] && !ign_mid[i];
    end
  end

  // Pairwise distances
  logic signed [TW:0] d_ab, d_ac, d_bc;
  logic [TW:0]        a_ab, a_ac, a_bc;
  logic [DCW-1:0]     e_ab, e_ac, e_bc, e_far, e_close;

  assign d_ab    = (TW+1)'(temp_q[0]) - (TW+1)'(temp_q[1]);
  assign d_ac    = (TW+1)'(temp_q[0]) - (TW+1)'(temp_q[2]);
  assign d_bc    = (TW+1)'(temp_q[1]) - (TW+1)'(temp_q[2]);
  assign a_ab    = d_ab[TW] ? (TW+1)'(-d_ab) : (TW+1)'(d_ab);
  assign a_ac    = d_ac[TW] ? (TW+1)'(-d_ac) : (TW+1)'(d_ac);
  assign a_bc    = d_bc[TW] ? (TW+1)'(-d_bc) : (TW+1)'(d_bc);
  assign e_ab    = DCW'(a_ab);
  assign e_ac    = DCW'(a_ac);
  assign e_bc    = DCW'(a_bc);
  assign e_far   = DCW'(far_q);
  assign e_close = DCW'(close_q);

  // Outlier vote, only with all three sensors valid; ties mark nobody
  logic [1:0] newf;

  always_comb begin
    newf = SENSOR_NONE;
    if (&valid_pre) begin
      if (e_ab > e_far && e_bc > e_far && e_ab > e_ac && e_bc > e_ac) begin
        newf = SENSOR_B;
      end else if (e_ac > e_close) begin
        if (e_ab > e_bc) begin
          newf = SENSOR_A;
        end else if (e_bc > e_ab) begin
          newf = SENSOR_C;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      newf_mask[i] = (newf == 2'(i));
    end
  end

  assign ign_nxt   = ign_mid | newf_mask;
  assign valid_fin = valid_pre & ~newf_mask;

  // Sum and count of the sensors used
  logic signed [TW+1:0] sum_v;
  logic [TW+1:0]        sum_abs;
  logic [1:0]           cnt_v;
  logic [1:0]           fidx_v;

  always_comb begin
    sum_v = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (valid_fin[i]) begin
        sum_v = sum_v + (TW+2)'(temp_q[i]);
      end
    end
  end

  assign sum_abs = sum_v[TW+1] ? (TW+2)'(-sum_v) : (TW+2)'(sum_v);
  assign cnt_v   = 2'(valid_fin[0]) + 2'(valid_fin[1]) + 2'(valid_fin[2]);
  assign fidx_v  = ign_nxt[2] ? SENSOR_C :
                   ign_nxt[1] ? SENSOR_B :
                   ign_nxt[0] ? SENSOR_A : SENSOR_NONE;

  // Startup hold and new deadline
  logic [CFG_TIME_W-1:0] start_t;
  logic [TLW-1:0]        start_ext, dl_sum;
  logic [MW-1:0]         elapsed;
  logic                  measured_v;

  assign start_t    = start_q;
  assign start_ext  = TLW'(start_t);
  assign elapsed    = now_q - start_ext[MW-1:0];
  assign measured_v = (TLW'(elapsed) >= TLW'(ign_time_q));
  assign dl_sum     = TLW'(now_q) + TLW'(ign_time_q);

  // Evaluation registers
  logic [TW:0] mag_q;
  logic        sign_q;
  logic [1:0]  cnt_q, newf_q, fidx_q;
  logic        measured_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ign_flag_q <= '0;
    end else if (cmd_i.eval) begin
      ign_flag_q <= ign_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        if (newf_mask[i]) begin
          deadline_q[i] <= dl_sum[MW-1:0];
        end
      end
      mag_q      <= sum_abs[TW:0];
      sign_q     <= sum_v[TW+1];
      cnt_q      <= cnt_v;
      newf_q     <= newf;
      fidx_q     <= fidx_v;
      measured_q <= measured_v;
    end
  end

  // Division by three through the reciprocal
  logic [PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= PW'(mag_q) * PW'(RECIP3);
    end
  end

  // Correct the estimate and pick the quotient for the sensor count
  logic [TW:0]          q0, q3, qsel, qneg;
  logic [TW+2:0]        rem3;
  logic signed [TW-1:0] mean_q;

  assign q0   = prod_q[RSH +: TW+1];
  assign rem3 = (TW+3)'(mag_q) - ((TW+3)'(q0) + {(TW+2)'(q0), 1'b0});
  assign q3   = q0 + (TW+1)'(rem3 >= (TW+3)'(3));

  always_comb begin
    case (cnt_q)
      2'd2:    qsel = mag_q >> 1;
      2'd3:    qsel = q3;
      default: qsel = mag_q;
    endcase
  end

  assign qneg = ~qsel + (TW+1)'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean) begin
      mean_q <= sign_q ? qneg[TW-1:0] : qsel[TW-1:0];
    end
  end

  // Alarms and window accumulation
  logic signed [SUMW-1:0] wsum_q, wsum_new, div_num_q;
  logic [CNTW-1:0]        wcnt_q, wcnt_new, div_den_q;
  logic [LENW-1:0]        len_eff;
  logic                   win_done;
  logic signed [DCW-1:0]  mean_ext, low_ext, high_ext;
  logic                   lo_q, hi_q, ready_q;

  assign wsum_new = wsum_q + SUMW'(mean_q);
  assign wcnt_new = wcnt_q + CNTW'(1);
  assign mean_ext = DCW'(mean_q);
  assign low_ext  = DCW'(low_q);
  assign high_ext = DCW'(high_q);

  always_comb begin
    if (wlen_q == '0) begin
      len_eff = LENW'(1);
    end else if (LENW'(wlen_q) > LENW'(WINDOW_MAX)) begin
      len_eff = LENW'(WINDOW_MAX);
    end else begin
      len_eff = LENW'(wlen_q);
    end
  end

  assign win_done = (LENW'(wcnt_new) >= len_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsum_q <= '0;
      wcnt_q <= '0;
    end else if (cmd_i.win && measured_q) begin
      wsum_q <= win_done ? '0 : wsum_new;
      wcnt_q <= win_done ? '0 : wcnt_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.win) begin
      lo_q      <= measured_q && (mean_ext < low_ext);
      hi_q      <= measured_q && (mean_ext > high_ext);
      ready_q   <= measured_q && win_done;
      div_num_q <= wsum_new;
      div_den_q <= wcnt_new;
    end
  end

  // Window mean divider
  logic                 div_busy;
  logic signed [TW-1:0] div_quot;

  tsf_div #(
    .NUM_W (SUMW),
    .DEN_W (CNTW),
    .Q_W   (TW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  // Result register
  logic [OUT_DW-1:0]    out_data_q;
  logic                 out_phase_q, out_last_q;
  logic [PACK_W-1:0]    pack;
  logic signed [TW-1:0] wmean;

  assign wmean = measured_q ? div_quot : '0;
  assign pack  = {wmean, newf_q, fidx_q, (fidx_q != SENSOR_NONE), hi_q, lo_q, cnt_q, mean_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q  <= OUT_DW'(pack);
      out_phase_q <= measured_q;
      out_last_q  <= ready_q;
    end
  end

  assign out_data_o  = out_data_q;
  assign out_phase_o = out_phase_q;
  assign out_last_o  = out_last_q;

  // Status to the sequencer
  assign status_o.any_valid = (cnt_q != 2'd0);
  assign status_o.measured  = measured_q;
  assign status_o.div_done  = !div_busy;

endmodule

`default_nettype wire

// ===== tb/sv/tb_triple_temp_sensor_fusion_top.sv =====
module tb_triple_temp_sensor_fusion_top;
  import tsf_pkg::*;

  localparam int unsigned TW     = TEMP_WIDTH_DEF;
  localparam int unsigned MW     = TIME_WIDTH_DEF;
  localparam int unsigned IN_W   = ((MW + 3*TW + 7) / 8) * 8;
  localparam int unsigned OUT_W  = ((2*TW + 9 + 7) / 8) * 8;
  // leave margin for rounds still in flight before touching registers
  localparam int unsigned SETTLE = 40;

  // Register setups used by the random phases
  typedef enum int {
    PROF_TYPICAL,
    PROF_WIDE,
    PROF_NARROW,
    PROF_LONG_WIN
  } cfg_profile_e;

  // One reading round
  typedef struct {
    logic [MW-1:0]        stamp;
    logic signed [TW-1:0] temp_a;
    logic signed [TW-1:0] temp_b;
    logic signed [TW-1:0] temp_c;
    logic [2:0]           present;
  } reading_t;

  // One fused result
  typedef struct {
    logic                 phase;
    logic signed [TW-1:0] mean_temp;
    logic [1:0]           valid_count;
    logic                 low_alarm;
    logic                 high_alarm;
    logic                 fault_flag;
    logic [1:0]           fault_index;
    logic [1:0]           new_fault_index;
    logic signed [TW-1:0] window_mean;
    logic                 window_ready;
  } fused_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic [2:0]           s_axis_tuser = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_LOW_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Predictor copy of the registers
  logic signed [15:0] lo_lim    = LOW_LIMIT_RST;
  logic signed [15:0] hi_lim    = HIGH_LIMIT_RST;
  logic [15:0]        pair_lim  = CLOSE_PAIR_RST;
  logic [15:0]        far_lim   = FAR_SENSOR_RST;
  logic [31:0]        ign_ms    = IGNORE_TIME_RST;
  logic [31:0]        start_ms  = START_TIME_RST;
  logic [6:0]         win_len   = WINDOW_LEN_RST;

  // Predictor copy of the fusion state
  bit            ign_flag [3]     = '{default: 1'b0};
  logic [MW-1:0] ign_deadline [3] = '{default: '0};
  longint        win_sum = 0;
  int            win_cnt = 0;

  fused_t        pending_fusions [$];
  int unsigned   fail_count = 0;
  int unsigned   src_idle_pct = 0;
  int unsigned   snk_stall_pct = 0;
  logic [MW-1:0] now_ms = 32'd600000;

  triple_temp_sensor_fusion_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Fuse one round: expire timers, vote, average, alarms and window
  function automatic bit fuse_round(input reading_t rd, output fused_t res);
    int            t [3];
    bit            ok [3];
    logic [MW-1:0] dt;
    logic [MW-1:0] elapsed;
    logic [1:0]    newf;
    logic [1:0]    fidx;
    int            dab, dac, dbc, cnt, eff_len;
    longint        sum, mean, wmean;
    t[0] = rd.temp_a;
    t[1] = rd.temp_b;
    t[2] = rd.temp_c;
    newf = SENSOR_NONE;
    // a deadline has passed when the wrapped distance is non-negative
    for (int i = 0; i < 3; i++) begin
      dt = rd.stamp - ign_deadline[i];
      if (ign_flag[i] && !dt[MW-1]) ign_flag[i] = 1'b0;
      ok[i] = rd.present[i] && !ign_flag[i];
    end
    // vote only when all three sensors are usable
    if (ok[0] && ok[1] && ok[2]) begin
      dab = (t[0] > t[1]) ? t[0] - t[1] : t[1] - t[0];
      dac = (t[0] > t[2]) ? t[0] - t[2] : t[2] - t[0];
      dbc = (t[1] > t[2]) ? t[1] - t[2] : t[2] - t[1];
      if (dab > int'(far_lim) && dbc > int'(far_lim) && dab > dac && dbc > dac) begin
        newf = SENSOR_B;
      end else if (dac > int'(pair_lim)) begin
        if (dab > dbc) newf = SENSOR_A;
        else if (dbc > dab) newf = SENSOR_C;
      end
      if (newf != SENSOR_NONE) begin
        ok[newf] = 1'b0;
        ign_flag[newf] = 1'b1;
        ign_deadline[newf] = rd.stamp + ign_ms;
      end
    end
    sum = 0;
    cnt = 0;
    for (int i = 0; i < 3; i++) begin
      if (ok[i]) begin
        sum += t[i];
        cnt++;
      end
    end
    if (cnt == 0) return 1'b0;
    mean = sum / cnt;
    fidx = SENSOR_NONE;
    for (int i = 0; i < 3; i++) begin
      if (ign_flag[i]) fidx = 2'(i);
    end
    res.phase = 1'b0;
    res.mean_temp = mean[TW-1:0];
    res.valid_count = cnt[1:0];
    res.low_alarm = 1'b0;
    res.high_alarm = 1'b0;
    res.fault_flag = (fidx != SENSOR_NONE);
    res.fault_index = fidx;
    res.new_fault_index = newf;
    res.window_mean = '0;
    res.window_ready = 1'b0;
    // outside the startup hold: alarms and window mean
    elapsed = rd.stamp - start_ms;
    if (elapsed >= ign_ms) begin
      eff_len = (win_len == 0) ? 1 : (win_len > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : win_len;
      res.phase = 1'b1;
      res.low_alarm = (mean < lo_lim);
      res.high_alarm = (mean > hi_lim);
      win_sum += mean;
      win_cnt++;
      wmean = win_sum / win_cnt;
      res.window_mean = wmean[TW-1:0];
      if (win_cnt >= eff_len) begin
        res.window_ready = 1'b1;
        win_sum = 0;
        win_cnt = 0;
      end
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      if (fail_count < 10) $display("%0t %s mismatch: expected %0h, got %0h",
                                    $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare every result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    fused_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_fusions.size() == 0) begin
        if (fail_count < 10) $display("%0t unexpected result: tdata %0h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_fusions.pop_front();
        check_field("phase", want.phase, m_axis_tuser);
        check_field("mean_temp", want.mean_temp, m_axis_tdata[TW-1:0]);
        check_field("valid_count", want.valid_count, m_axis_tdata[TW+1:TW]);
        check_field("low_alarm", want.low_alarm, m_axis_tdata[TW+2]);
        check_field("high_alarm", want.high_alarm, m_axis_tdata[TW+3]);
        check_field("fault_flag", want.fault_flag, m_axis_tdata[TW+4]);
        check_field("fault_index", want.fault_index, m_axis_tdata[TW+6:TW+5]);
        check_field("new_fault_index", want.new_fault_index, m_axis_tdata[TW+8:TW+7]);
        check_field("window_mean", want.window_mean, m_axis_tdata[2*TW+8:TW+9]);
        check_field("pad", '0, m_axis_tdata[OUT_W-1:2*TW+9]);
        check_field("window_ready", want.window_ready, m_axis_tlast);
      end
    end
  end

  // Send one reading round and record what it should produce
  task automatic push_round(input logic [MW-1:0] stamp, input int a, input int b,
                            input int c, input logic [2:0] pres);
    reading_t rd;
    fused_t   res;
    rd.stamp = stamp;
    rd.temp_a = a[TW-1:0];
    rd.temp_b = b[TW-1:0];
    rd.temp_c = c[TW-1:0];
    rd.present = pres;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata <= IN_W'({rd.temp_c, rd.temp_b, rd.temp_a, rd.stamp});
    s_axis_tuser <= rd.present;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (fuse_round(rd, res)) pending_fusions.push_back(res);
  endtask

  // Let the block drain; rounds without a result may still be in flight
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (pending_fusions.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LOW_LIMIT:   lo_lim = val[15:0];
      CFG_HIGH_LIMIT:  hi_lim = val[15:0];
      CFG_CLOSE_PAIR:  pair_lim = val[15:0];
      CFG_FAR_SENSOR:  far_lim = val[15:0];
      CFG_IGNORE_TIME: ign_ms = val;
      CFG_START_TIME:  start_ms = val;
      CFG_WINDOW_LEN:  win_len = val[6:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write all registers; unused upper data bits get random junk
  task automatic set_profile(input cfg_profile_e prof);
    logic [15:0] lo_v, hi_v, pair_v, far_v;
    logic [31:0] hold_v, start_v;
    logic [6:0]  len_v;
    case (prof)
      PROF_WIDE: begin
        lo_v = 16'h8000;
        hi_v = 16'h7fff;
        pair_v = 16'hffff;
        far_v = 16'hffff;
        hold_v = 32'hffff_ffff;
        start_v = $urandom();
        len_v = 7'd127;
      end
      PROF_NARROW: begin
        lo_v = 16'h7fff;
        hi_v = 16'h8000;
        pair_v = '0;
        far_v = '0;
        hold_v = '0;
        start_v = '0;
        len_v = '0;
      end
      default: begin
        lo_v = 16'($urandom_range(0, 6000) - 3000);
        hi_v = lo_v + 16'($urandom_range(0, 8000));
        pair_v = 16'($urandom_range(40, 400));
        far_v = 16'($urandom_range(100, 800));
        hold_v = $urandom_range(10000, 60000);
        start_v = now_ms - 32'($urandom_range(0, 120000));
        len_v = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(13, 127))
                                            : 7'($urandom_range(1, 12));
        if (prof == PROF_LONG_WIN) len_v = 7'd127;
      end
    endcase
    write_reg(CFG_LOW_LIMIT, {16'($urandom()), lo_v});
    write_reg(CFG_HIGH_LIMIT, {16'($urandom()), hi_v});
    write_reg(CFG_CLOSE_PAIR, {16'($urandom()), pair_v});
    write_reg(CFG_FAR_SENSOR, {16'($urandom()), far_v});
    write_reg(CFG_IGNORE_TIME, hold_v);
    write_reg(CFG_START_TIME, start_v);
    write_reg(CFG_WINDOW_LEN, {25'($urandom()), len_v});
  endtask

  // Rounds inside the power-on hold, with reset register values
  task automatic test_startup_hold();
    push_round(32'd1000, 100, 110, 105, 3'b111);
    push_round(32'd2000, 32767, 32767, 32767, 3'b111);
    push_round(32'd3000, -32768, -32768, -32768, 3'b111);
    push_round(32'd4000, 50, 60, 70, 3'b000);
    push_round(32'd5000, -7, 0, 0, 3'b001);
    push_round(32'd6000, -3, 999, -4, 3'b101);
    push_round(32'd7000, 0, 1000, 10, 3'b111);
  endtask

  // Middle and end outliers, exact timer expiry, tie
  task automatic test_fault_vote();
    wait_quiet();
    write_reg(CFG_IGNORE_TIME, 32'd1000);
    write_reg(CFG_START_TIME, 32'd0);
    push_round(32'd200000, 0, 1000, 10, 3'b111);
    push_round(32'd200500, 0, 1000, 10, 3'b111);
    push_round(32'd201000, 0, 1000, 10, 3'b111);
    push_round(32'd202000, 500, 0, 10, 3'b111);
    push_round(32'd203000, 0, 200, 400, 3'b111);
    push_round(32'd204000, 0, 10, 500, 3'b111);
    push_round(32'd204001, 0, 10, 500, 3'b111);
  endtask

  // Ignore time past half the timer range expires on the next round
  task automatic test_ignore_wrap();
    wait_quiet();
    write_reg(CFG_IGNORE_TIME, 32'hc000_0000);
    write_reg(CFG_START_TIME, 32'h3000_0000);
    push_round(32'd300000, 0, 1000, 10, 3'b111);
    push_round(32'd300001, 0, 1000, 10, 3'b111);
  endtask

  // Below, at and above the default limits
  task automatic test_alarm_limits();
    wait_quiet();
    write_reg(CFG_IGNORE_TIME, 32'd0);
    write_reg(CFG_START_TIME, 32'd0);
    push_round(32'd400000, -100, -100, -100, 3'b111);
    push_round(32'd400010, 256, 256, 256, 3'b111);
    push_round(32'd400020, 6000, 6000, 6000, 3'b111);
  endtask

  // Length zero acts as one; shrinking the length closes an open window
  task automatic test_window_lengths();
    wait_quiet();
    write_reg(CFG_WINDOW_LEN, 32'd0);
    push_round(32'd500000, 10, 20, 30, 3'b111);
    push_round(32'd500010, -10, -20, -31, 3'b111);
    wait_quiet();
    write_reg(CFG_WINDOW_LEN, 32'd64);
    push_round(32'd500020, 1, 2, 3, 3'b111);
    push_round(32'd500030, -5, -5, -5, 3'b111);
    push_round(32'd500040, 7, 7, 8, 3'b111);
    wait_quiet();
    write_reg(CFG_WINDOW_LEN, 32'd2);
    push_round(32'd500050, 9, 9, 9, 3'b111);
  endtask

  // Mostly plausible rounds with an occasional outlier, dropout or wild value
  task automatic random_phase(input int unsigned count, input int unsigned src_pct,
                              input int unsigned snk_pct, input cfg_profile_e prof);
    int         t [3];
    int         base;
    int         pick;
    logic [2:0] pres;
    wait_quiet();
    set_profile(prof);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    repeat (count) begin
      if ($urandom_range(0, 29) == 0) now_ms = $urandom();
      else now_ms += $urandom_range(1, 20000);
      base = int'($urandom_range(0, 12000)) - 4000;
      for (int i = 0; i < 3; i++) t[i] = base + int'($urandom_range(0, 200)) - 100;
      if ($urandom_range(0, 4) == 0) begin
        pick = $urandom_range(0, 2);
        t[pick] += int'($urandom_range(200, 2000)) * (($urandom_range(0, 1) == 1) ? 1 : -1);
      end
      if ($urandom_range(0, 19) == 0) begin
        for (int i = 0; i < 3; i++) t[i] = int'($urandom_range(0, 65535)) - 32768;
      end
      pres = ($urandom_range(0, 4) != 0) ? 3'b111 : 3'($urandom_range(0, 7));
      push_round(now_ms, t[0], t[1], t[2], pres);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_startup_hold();
    test_fault_vote();
    test_ignore_wrap();
    test_alarm_limits();
    test_window_lengths();
    random_phase(100, 0, 0, PROF_TYPICAL);
    random_phase(100, 53, 0, PROF_TYPICAL);
    random_phase(60, 0, 53, PROF_WIDE);
    random_phase(60, 23, 23, PROF_NARROW);
    random_phase(115, 0, 0, PROF_LONG_WIN);
    random_phase(115, 0, 53, PROF_TYPICAL);
    wait_quiet();
    if (fail_count == 0) begin
      $display("tb_triple_temp_sensor_fusion_top OK");
    end else begin
      $display("tb_triple_temp_sensor_fusion_top NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("tb_triple_temp_sensor_fusion_top NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tsf_pkg.sv
rtl/tsf_div.sv
rtl/tsf_ctrl.sv
rtl/tsf_dp.sv
rtl/triple_temp_sensor_fusion_top.sv
tb/sv/tb_triple_temp_sensor_fusion_top.sv
